[hw/rtl/gmhr_pkg.sv]
// ----------------------------------------------------------------------------
// gmhr_pkg
// Shared types, constants and helper functions of the gain-map HDR block.
// ----------------------------------------------------------------------------
package gmhr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LOG_LAT   = 17;
  localparam int EXP_LAT   = 16;
  localparam logic [16:0] ONE_Q = 17'(1 << FRAC_BITS);

  typedef enum logic [2:0] {
    REG_GAIN_MIN  = 3'd0,
    REG_GAIN_MAX  = 3'd1,
    REG_INV_GAMMA = 3'd2,
    REG_BASE_OFS  = 3'd3,
    REG_ALT_OFS   = 3'd4,
    REG_WEIGHT    = 3'd5
  } reg_idx_t;

  // per-word sideband that travels down the pipe
  typedef struct packed {
    logic signed [23:0] base;
    logic [1:0]         ch;
    logic               last;
    logic               e_zero;
    logic               g_zero;
    logic signed [10:0] ex;
  } side_t;

  function automatic logic [15:0] lane16(input logic [47:0] regv, input logic [1:0] ch);
    logic [15:0] res;
    case (ch)
      2'd0:    res = regv[15:0];
      2'd1:    res = regv[31:16];
      default: res = regv[47:32];
    endcase
    return res;
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned res;
    longint unsigned bq;
    longint unsigned rem;
    res = 0;
    bq  = 64'd1 << 62;
    rem = v;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bq) begin
        rem = rem - (res + bq);
        res = (res >> 1) + bq;
      end else begin
        res = res >> 1;
      end
      bq = bq >> 2;
    end
    return res;
  endfunction

  // 2^(2^-k) in Q1.30 by repeated floor square roots starting from 2.0
  function automatic logic [30:0] exp2_root(input int k);
    longint unsigned c;
    c = 64'd1 << 31;
    for (int j = 1; j <= 16; j++) begin
      if (j <= k) begin
        c = isqrt64(c << 30);
      end
    end
    return c[30:0];
  endfunction

endpackage

[hw/rtl/gmhr_log2.sv]
// ----------------------------------------------------------------------------
// gmhr_log2
// Pipelined log2 of a Q.16 value: normalize, then one square-and-compare
// step per stage, sixteen fraction bits.
// ----------------------------------------------------------------------------
module gmhr_log2
  import gmhr_pkg::*;
(
  input  logic        clk,
  input  logic        adv,
  input  logic [16:0] e_in,
  output logic [4:0]  p_out,
  output logic [15:0] frac_out
);

  logic [30:0] m_r  [0:16];
  logic [4:0]  p_r  [0:16];
  logic [15:0] fr_r [0:16];

  logic [4:0]  p_nxt;
  logic [30:0] m_nxt;

  always_comb begin
    p_nxt = 5'd0;
    for (int j = 0; j < 17; j++) begin
      if (e_in[j]) begin
        p_nxt = 5'(j);
      end
    end
    m_nxt = {14'd0, e_in} << (5'd30 - p_nxt);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0]  <= m_nxt;
      p_r[0]  <= p_nxt;
      fr_r[0] <= 16'd0;
    end
  end

  for (genvar k = 1; k <= 16; k++) begin : g_step
    logic [61:0] sq;
    logic [31:0] mm;
    assign sq = 62'(m_r[k-1]) * 62'(m_r[k-1]);
    assign mm = sq[61:30];
    always_ff @(posedge clk) begin
      if (adv) begin
        m_r[k]  <= mm[31] ? mm[31:1] : mm[30:0];
        p_r[k]  <= p_r[k-1];
        fr_r[k] <= {fr_r[k-1][14:0], mm[31]};
      end
    end
  end

  assign p_out    = p_r[16];
  assign frac_out = fr_r[16];

endmodule

[hw/rtl/gmhr_exp2.sv]
// ----------------------------------------------------------------------------
// gmhr_exp2
// Pipelined 2^f for a 16-bit fraction: one root constant multiply per stage,
// mantissa in Q1.30.
// ----------------------------------------------------------------------------
module gmhr_exp2
  import gmhr_pkg::*;
(
  input  logic        clk,
  input  logic        adv,
  input  logic [15:0] frac_in,
  output logic [30:0] mant_out
);

  logic [30:0] r_r [1:16];
  logic [15:0] f_r [1:16];

  for (genvar k = 1; k <= 16; k++) begin : g_step
    localparam logic [30:0] ROOT = exp2_root(k);
    logic [30:0] r_prev;
    logic [15:0] f_prev;
    logic [61:0] prod;
    logic [62:0] rnd_sum;
    if (k == 1) begin : g_first
      assign r_prev = 31'(64'd1 << 30);
      assign f_prev = frac_in;
    end else begin : g_next
      assign r_prev = r_r[k-1];
      assign f_prev = f_r[k-1];
    end
    assign prod    = 62'(r_prev) * 62'(ROOT);
    assign rnd_sum = 63'(prod) + 63'(64'd1 << 29);
    always_ff @(posedge clk) begin
      if (adv) begin
        r_r[k] <= f_prev[16-k] ? rnd_sum[60:30] : r_prev;
        f_r[k] <= f_prev;
      end
    end
  end

  assign mant_out = r_r[16];

endmodule

[hw/rtl/gain_map_hdr_reconstruct_unit.sv]
// ----------------------------------------------------------------------------
// gain_map_hdr_reconstruct_unit
// Gain-map HDR reconstruction, one color component per word.
//
//  channel | group             | contents
//  in      | in_t*   (stream)  | base, four gain samples, fractions; tuser lane
//  out     | out_t*  (stream)  | value, clamp flags, clamp counters
//  cfg     | cfg_p*  (APB)     | six registers at 8-byte spacing
//
// one word per cycle sustained while the output is not stalled
// (two 16-stage exp2 units and the 17-stage log2 unit hold most of the pipe registers)
// the whole pipe advances when the output register is empty or taken
// synchronous active-low reset clears valids, counters and registers
// ----------------------------------------------------------------------------
module gain_map_hdr_reconstruct_unit
  import gmhr_pkg::*;
#(
  parameter  int COUNTER_WIDTH = 40,
  localparam int OUT_W = ((26 + 2 * COUNTER_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // base_value, gain_top_left, gain_top_right, gain_bottom_left,
  // gain_bottom_right, frac_x, frac_y
  input  logic [127:0]     in_tdata,
  input  logic             in_tlast,
  // metadata_channel
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // out_value, value_clamped, pixel_clamp_flag, clamp_value_total, clamp_pixel_total
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [5:0]       cfg_paddr,
  input  logic [63:0]      cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  // ---------------- configuration ----------------
  logic [47:0] gain_min_r, gain_max_r, inv_gamma_r, base_ofs_r, alt_ofs_r;
  logic [16:0] weight_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_min_r  <= '0;
      gain_max_r  <= '0;
      inv_gamma_r <= 48'h1000_1000_1000;
      base_ofs_r  <= '0;
      alt_ofs_r   <= '0;
      weight_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_MIN:  gain_min_r  <= cfg_pwdata[47:0];
        REG_GAIN_MAX:  gain_max_r  <= cfg_pwdata[47:0];
        REG_INV_GAMMA: inv_gamma_r <= cfg_pwdata[47:0];
        REG_BASE_OFS:  base_ofs_r  <= cfg_pwdata[47:0];
        REG_ALT_OFS:   alt_ofs_r   <= cfg_pwdata[47:0];
        REG_WEIGHT:    weight_r    <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN_MIN:  cfg_prdata = {16'd0, gain_min_r};
      REG_GAIN_MAX:  cfg_prdata = {16'd0, gain_max_r};
      REG_INV_GAMMA: cfg_prdata = {16'd0, inv_gamma_r};
      REG_BASE_OFS:  cfg_prdata = {16'd0, base_ofs_r};
      REG_ALT_OFS:   cfg_prdata = {16'd0, alt_ofs_r};
      REG_WEIGHT:    cfg_prdata = {47'd0, weight_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic out_valid_r;
  logic adv;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;

  // ---------------- stage A: horizontal interpolation ----------------
  logic signed [23:0] in_base;
  logic signed [17:0] g_tl, g_tr, g_bl, g_br;
  logic [15:0]        fx, fy;
  logic signed [18:0] d_top, d_bot;
  logic signed [35:0] p_top, p_bot;
  logic signed [35:0] r_top, r_bot;
  logic signed [19:0] top_nxt, bot_nxt;
  side_t              sd_a_nxt;

  logic               va_r;
  side_t              sd_a_r;
  logic signed [19:0] top_a_r, bot_a_r;

  assign in_base = in_tdata[23:0];
  assign g_tl    = in_tdata[41:24];
  assign g_tr    = in_tdata[59:42];
  assign g_bl    = in_tdata[77:60];
  assign g_br    = in_tdata[95:78];
  assign fx      = in_tdata[111:96];
  assign fy      = in_tdata[127:112];

  always_comb begin
    d_top   = 19'(g_tr) - 19'(g_tl);
    d_bot   = 19'(g_br) - 19'(g_bl);
    p_top   = 36'(d_top) * $signed({20'd0, fx});
    p_bot   = 36'(d_bot) * $signed({20'd0, fx});
    r_top   = (p_top + 36'sd32768) >>> FRAC_BITS;
    r_bot   = (p_bot + 36'sd32768) >>> FRAC_BITS;
    top_nxt = 20'(g_tl) + r_top[19:0];
    bot_nxt = 20'(g_bl) + r_bot[19:0];
    sd_a_nxt        = '0;
    sd_a_nxt.base   = in_base;
    sd_a_nxt.ch     = (in_tuser == 2'd3) ? 2'd2 : in_tuser;
    sd_a_nxt.last   = in_tlast;
  end

  logic [15:0] fy_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_a_r  <= sd_a_nxt;
      top_a_r <= top_nxt;
      bot_a_r <= bot_nxt;
      fy_a_r  <= fy;
    end
  end

  // ---------------- stage B: vertical interpolation, clamp ----------------
  logic signed [20:0] d_v;
  logic signed [37:0] p_v, r_v;
  logic signed [20:0] e_raw;
  logic [16:0]        e_nxt;
  side_t              sd_b_nxt;

  logic               vb_r;
  side_t              sd_b_r;
  logic [16:0]        e_b_r;

  always_comb begin
    d_v   = 21'(bot_a_r) - 21'(top_a_r);
    p_v   = 38'(d_v) * $signed({22'd0, fy_a_r});
    r_v   = (p_v + 38'sd32768) >>> FRAC_BITS;
    e_raw = 21'(top_a_r) + r_v[20:0];
    if (e_raw < 0) begin
      e_nxt = 17'd0;
    end else if (e_raw > $signed({4'd0, ONE_Q})) begin
      e_nxt = ONE_Q;
    end else begin
      e_nxt = e_raw[16:0];
    end
    sd_b_nxt        = sd_a_r;
    sd_b_nxt.e_zero = (e_nxt == 17'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_b_r <= sd_b_nxt;
      e_b_r  <= e_nxt;
    end
  end

  // ---------------- log2 unit ----------------
  logic [4:0]          lg_p;
  logic [15:0]         lg_frac;
  logic [LOG_LAT-1:0]  lv_r;
  side_t               lsd_r [0:LOG_LAT-1];

  gmhr_log2 u_log2 (
    .clk      (clk),
    .adv      (adv),
    .e_in     (e_b_r),
    .p_out    (lg_p),
    .frac_out (lg_frac)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
    end else if (adv) begin
      lv_r <= {lv_r[LOG_LAT-2:0], vb_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lsd_r[0] <= sd_b_r;
      for (int j = 1; j < LOG_LAT; j++) begin
        lsd_r[j] <= lsd_r[j-1];
      end
    end
  end

  // ---------------- stage C: scale log by reciprocal gamma ----------------
  side_t              sd_l;
  logic [15:0]        gam;
  logic [5:0]         p_off;
  logic signed [21:0] lg;
  logic signed [38:0] lg_prod, t_full;
  logic [26:0]        t_nxt;
  side_t              sd_c_nxt;

  logic               vc_r;
  side_t              sd_c_r;
  logic [26:0]        t_c_r;

  always_comb begin
    sd_l    = lsd_r[LOG_LAT-1];
    gam     = lane16(inv_gamma_r, sd_l.ch);
    p_off   = {1'b0, lg_p} - 6'd16;
    lg      = $signed({p_off, lg_frac});
    lg_prod = 39'(lg) * $signed({23'd0, gam});
    t_full  = (lg_prod + 39'sd2048) >>> 12;
    t_nxt   = t_full[26:0];
    sd_c_nxt        = sd_l;
    sd_c_nxt.g_zero = (gam == 16'd0);
    sd_c_nxt.ex     = $signed(t_nxt[26:16]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= lv_r[LOG_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_c_r <= sd_c_nxt;
      t_c_r  <= t_nxt;
    end
  end

  // ---------------- first exp2 unit: power ----------------
  logic [30:0]        pw_mant;
  logic [EXP_LAT-1:0] xv_r;
  side_t              xsd_r [0:EXP_LAT-1];

  gmhr_exp2 u_exp2_pow (
    .clk      (clk),
    .adv      (adv),
    .frac_in  (t_c_r[15:0]),
    .mant_out (pw_mant)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xv_r <= '0;
    end else if (adv) begin
      xv_r <= {xv_r[EXP_LAT-2:0], vc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xsd_r[0] <= sd_c_r;
      for (int j = 1; j < EXP_LAT; j++) begin
        xsd_r[j] <= xsd_r[j-1];
      end
    end
  end

  // ---------------- stage D: power to Q.16 ----------------
  side_t       sd_x;
  logic [10:0] neg_ex;
  logic [4:0]  sh_p;
  logic [31:0] pw_sum;
  logic [16:0] pw_nxt;

  logic        vd_r;
  side_t       sd_d_r;
  logic [16:0] pw_d_r;

  always_comb begin
    sd_x   = xsd_r[EXP_LAT-1];
    neg_ex = 11'd0 - sd_x.ex;
    sh_p   = 5'(neg_ex + 11'd14);
    pw_sum = {1'b0, pw_mant} + (32'd1 << (sh_p - 5'd1));
    if (sd_x.e_zero) begin
      pw_nxt = sd_x.g_zero ? ONE_Q : 17'd0;
    end else if (neg_ex > 11'd17) begin
      pw_nxt = 17'd0;
    end else begin
      pw_nxt = 17'(pw_sum >> sh_p);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (adv) begin
      vd_r <= xv_r[EXP_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_d_r <= sd_x;
      pw_d_r <= pw_nxt;
    end
  end

  // ---------------- stage E: log gain between min and max ----------------
  logic signed [15:0] lmin, lmax;
  logic signed [16:0] ldiff;
  logic signed [34:0] lprod, lrnd;
  logic signed [17:0] l_nxt;

  logic               ve_r;
  side_t              sd_e_r;
  logic signed [17:0] l_e_r;

  always_comb begin
    lmin  = $signed(lane16(gain_min_r, sd_d_r.ch));
    lmax  = $signed(lane16(gain_max_r, sd_d_r.ch));
    ldiff = 17'(lmax) - 17'(lmin);
    lprod = 35'(ldiff) * $signed({18'd0, pw_d_r});
    lrnd  = (lprod + 35'sd32768) >>> FRAC_BITS;
    l_nxt = 18'(lmin) + lrnd[17:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv) begin
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_e_r <= sd_d_r;
      l_e_r  <= l_nxt;
    end
  end

  // ---------------- stage F: weight by headroom ----------------
  logic [16:0]        w_clamp;
  logic signed [35:0] xprod, xrnd;
  logic signed [21:0] x_nxt;
  side_t              sd_f_nxt;

  logic               vf_r;
  side_t              sd_f_r;
  logic signed [21:0] x_f_r;

  always_comb begin
    w_clamp = (weight_r > ONE_Q) ? ONE_Q : weight_r;
    xprod   = 36'(l_e_r) * $signed({19'd0, w_clamp});
    xrnd    = (xprod + 36'sd1024) >>> 11;
    x_nxt   = xrnd[21:0];
    sd_f_nxt    = sd_e_r;
    sd_f_nxt.ex = {{5{x_nxt[21]}}, x_nxt[21:16]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (adv) begin
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_f_r <= sd_f_nxt;
      x_f_r  <= x_nxt;
    end
  end

  // ---------------- second exp2 unit: gain ----------------
  logic [30:0]        gn_mant;
  logic [EXP_LAT-1:0] yv_r;
  side_t              ysd_r [0:EXP_LAT-1];

  gmhr_exp2 u_exp2_gain (
    .clk      (clk),
    .adv      (adv),
    .frac_in  (x_f_r[15:0]),
    .mant_out (gn_mant)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yv_r <= '0;
    end else if (adv) begin
      yv_r <= {yv_r[EXP_LAT-2:0], vf_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ysd_r[0] <= sd_f_r;
      for (int j = 1; j < EXP_LAT; j++) begin
        ysd_r[j] <= ysd_r[j-1];
      end
    end
  end

  // ---------------- stage G: apply gain to offset base ----------------
  side_t              sd_y;
  logic [31:0]        m_sum;
  logic [29:0]        mant28;
  logic signed [24:0] s_base;
  logic signed [55:0] g_prod;

  logic               vg_r;
  side_t              sd_g_r;
  logic signed [55:0] prod_g_r;

  always_comb begin
    sd_y   = ysd_r[EXP_LAT-1];
    m_sum  = {1'b0, gn_mant} + 32'd2;
    mant28 = m_sum[31:2];
    s_base = 25'(sd_y.base) + 25'($signed({lane16(base_ofs_r, sd_y.ch), 2'b00}));
    g_prod = 56'(s_base) * $signed({26'd0, mant28});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (adv) begin
      vg_r <= yv_r[EXP_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_g_r   <= sd_y;
      prod_g_r <= g_prod;
    end
  end

  // ---------------- stage H: exponent shift, alternate offset ----------------
  logic signed [11:0] sh_s;
  logic [5:0]         sh_g;
  logic signed [56:0] v_shift;
  logic signed [45:0] v_nxt;

  logic               vh_r;
  logic               last_h_r;
  logic signed [45:0] v_h_r;

  always_comb begin
    sh_s    = 12'sd28 - 12'(sd_g_r.ex);
    sh_g    = sh_s[5:0];
    v_shift = (57'(prod_g_r) + (57'sd1 <<< (sh_g - 6'd1))) >>> sh_g;
    v_nxt   = v_shift[45:0] - 46'($signed({lane16(alt_ofs_r, sd_g_r.ch), 2'b00}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= 1'b0;
    end else if (adv) begin
      vh_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_h_r <= sd_g_r.last;
      v_h_r    <= v_nxt;
    end
  end

  // ---------------- output register, clamp and counters ----------------
  logic [23:0]              oval_nxt;
  logic                     vcl_nxt, pcl_nxt, seen_nxt;
  logic [COUNTER_WIDTH-1:0] cval_nxt, cpix_nxt;

  logic [23:0]              oval_r;
  logic                     vcl_r, pcl_r, seen_r;
  logic [COUNTER_WIDTH-1:0] cval_r, cpix_r;

  always_comb begin
    vcl_nxt  = 1'b0;
    cval_nxt = cval_r;
    cpix_nxt = cpix_r;
    pcl_nxt  = 1'b0;
    seen_nxt = seen_r;
    if (v_h_r < 0) begin
      oval_nxt = 24'd0;
      vcl_nxt  = 1'b1;
    end else if (v_h_r > 46'sh0FF_FFFF) begin
      oval_nxt = 24'hFF_FFFF;
    end else begin
      oval_nxt = v_h_r[23:0];
    end
    if (vcl_nxt && (cval_r != '1)) begin
      cval_nxt = cval_r + 1'b1;
    end
    if (last_h_r) begin
      pcl_nxt  = seen_r | vcl_nxt;
      seen_nxt = 1'b0;
      if (pcl_nxt && (cpix_r != '1)) begin
        cpix_nxt = cpix_r + 1'b1;
      end
    end else if (vcl_nxt) begin
      seen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cval_r      <= '0;
      cpix_r      <= '0;
      seen_r      <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vh_r;
      if (vh_r) begin
        cval_r <= cval_nxt;
        cpix_r <= cpix_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vh_r) begin
      oval_r <= oval_nxt;
      vcl_r  <= vcl_nxt;
      pcl_r  <= pcl_nxt;
    end
  end

  assign out_tdata = OUT_W'({cpix_r, cval_r, pcl_r, vcl_r, oval_r});

endmodule

[hw/rtl/gmhr_checker.sv]
// ----------------------------------------------------------------------------
// gmhr_checker
// Port-level checks of the gain-map HDR block, bound to the top level.
// ----------------------------------------------------------------------------
module gmhr_checker #(
  parameter  int COUNTER_WIDTH = 40,
  localparam int OUT_W = ((26 + 2 * COUNTER_WIDTH + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int VT_LO = 26;
  localparam int VT_HI = 25 + COUNTER_WIDTH;
  localparam int PT_LO = 26 + COUNTER_WIDTH;
  localparam int PT_HI = 25 + 2 * COUNTER_WIDTH;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // clamped component reads zero
  a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24] |-> out_tdata[23:0] == 24'd0)
    else $error("clamped component not zero");

  // counters never go down
  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> out_tdata[VT_HI:VT_LO] >= $past(out_tdata[VT_HI:VT_LO]) &&
                     out_tdata[PT_HI:PT_LO] >= $past(out_tdata[PT_HI:PT_LO]))
    else $error("clamp counter decreased");

  // empty or taken output register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with free output");

endmodule

bind gain_map_hdr_reconstruct_unit gmhr_checker #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_gmhr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
